### sv/deq_pkg.sv
// shared types and codes for the double-ended queue
package deq_pkg;

    localparam int IO_W = 32;

    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic push_front;
        logic push_back;
        logic pop_front;
        logic pop_back;
    } deq_ctrl_t;

endpackage

### sv/deq_cell.sv
// one storage cell of the deque shift chain
module deq_cell
    import deq_pkg::*;
#(
    parameter int WORD_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  deq_ctrl_t             ctrl,
    input  logic [WORD_WIDTH-1:0] left_data,
    input  logic                  left_occ,
    input  logic [WORD_WIDTH-1:0] right_data,
    input  logic                  right_occ,
    input  logic [WORD_WIDTH-1:0] push_word,
    output logic [WORD_WIDTH-1:0] data,
    output logic                  occ,
    output logic [WORD_WIDTH-1:0] tail_word
);

    logic [WORD_WIDTH-1:0] data_reg;
    logic [WORD_WIDTH-1:0] data_next;
    logic                  occ_reg;
    logic                  occ_next;
    logic                  is_tail;
    logic                  is_slot;

    assign is_tail = occ_reg && !right_occ;
    assign is_slot = !occ_reg && left_occ;

    always_comb
    begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (ctrl.push_front)
        begin
            data_next = left_data;
            occ_next  = left_occ;
        end
        else if (ctrl.pop_front)
        begin
            data_next = right_data;
            occ_next  = right_occ;
        end
        else if (ctrl.push_back && is_slot)
        begin
            data_next = push_word;
            occ_next  = 1'b1;
        end
        else if (ctrl.pop_back && is_tail)
        begin
            occ_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data      = data_reg;
    assign occ       = occ_reg;
    assign tail_word = data_reg & {WORD_WIDTH{is_tail}};

endmodule

### sv/double_ended_queue_unit.sv
// top level of the double-ended queue built from a chain of cells
//
// requests enter on in_valid/in_ready with req_type and push_value; every
// request gives exactly one result word on out_valid/out_ready carrying
// pop_value, status, fill_count, is_empty and is_full.
// the front of the deque is always cell 0; a push at the front shifts the
// whole chain one cell back, a pop at the front shifts it one cell forward.
// the back is the last occupied cell, found locally by each cell.
// out_valid rises in the cycle after acceptance; one request is taken per
// cycle while results are taken, set by the single output register stage.
// in_ready stays high while the output register is empty or being drained,
// so a stalled receiver holds at most one finished result and then blocks
// new requests until it is taken.
// reset empties the deque and the output register at once; stored words
// are not cleared.
// a pop on an empty deque returns 0 with an empty status, a push on a full
// deque is dropped with a full status.
module double_ended_queue_unit
    import deq_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     req_type,
    input  logic signed [IO_W-1:0]         push_value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [IO_W-1:0]         pop_value,
    output logic [1:0]                     status,
    output logic [$clog2(DEPTH+1)-1:0]     fill_count,
    output logic                           is_empty,
    output logic                           is_full
);

    localparam int COUNT_W = $clog2(DEPTH + 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);
    localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);

    logic [WORD_WIDTH-1:0] cell_data [DEPTH];
    logic [WORD_WIDTH-1:0] cell_tail [DEPTH];
    logic [DEPTH-1:0]      cell_occ;

    logic [WORD_WIDTH-1:0] push_word;
    logic [WORD_WIDTH-1:0] tail_word;
    logic [IO_W-1:0]       front_ext;
    logic [IO_W-1:0]       tail_ext;
    logic                  accept;
    logic                  deq_full;
    logic                  deq_empty;
    deq_ctrl_t             ctrl;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [IO_W-1:0]       pop_value_reg;
    logic [IO_W-1:0]       pop_value_next;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [COUNT_W-1:0]    count_reg;
    logic [COUNT_W-1:0]    count_next;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign deq_full  = cell_occ[DEPTH-1];
    assign deq_empty = !cell_occ[0];

    generate
        if (WORD_WIDTH <= IO_W)
        begin : g_push_narrow
            assign push_word = push_value[WORD_WIDTH-1:0];
        end
        else
        begin : g_push_wide
            assign push_word = {{(WORD_WIDTH-IO_W){1'b0}}, push_value};
        end

        if (WORD_WIDTH >= IO_W)
        begin : g_pop_wide
            assign front_ext = cell_data[0][IO_W-1:0];
            assign tail_ext  = tail_word[IO_W-1:0];
        end
        else
        begin : g_pop_narrow
            assign front_ext = {{(IO_W-WORD_WIDTH){cell_data[0][WORD_WIDTH-1]}},
                                cell_data[0]};
            assign tail_ext  = {{(IO_W-WORD_WIDTH){tail_word[WORD_WIDTH-1]}},
                                tail_word};
        end
    endgenerate

    always_comb
    begin
        ctrl.push_front = accept && (req_type == REQ_PUSH_FRONT) && !deq_full;
        ctrl.push_back  = accept && (req_type == REQ_PUSH_BACK)  && !deq_full;
        ctrl.pop_front  = accept && (req_type == REQ_POP_FRONT)  && !deq_empty;
        ctrl.pop_back   = accept && (req_type == REQ_POP_BACK)   && !deq_empty;
    end

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [WORD_WIDTH-1:0] left_data;
            logic                  left_occ;
            logic [WORD_WIDTH-1:0] right_data;
            logic                  right_occ;

            if (gi == 0)
            begin : g_first
                assign left_data = push_word;
                assign left_occ  = 1'b1;
            end
            else
            begin : g_mid_left
                assign left_data = cell_data[gi-1];
                assign left_occ  = cell_occ[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign right_data = '0;
                assign right_occ  = 1'b0;
            end
            else
            begin : g_mid_right
                assign right_data = cell_data[gi+1];
                assign right_occ  = cell_occ[gi+1];
            end

            deq_cell #(
                .WORD_WIDTH (WORD_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .left_data  (left_data),
                .left_occ   (left_occ),
                .right_data (right_data),
                .right_occ  (right_occ),
                .push_word  (push_word),
                .data       (cell_data[gi]),
                .occ        (cell_occ[gi]),
                .tail_word  (cell_tail[gi])
            );
        end
    endgenerate

    // only the last occupied cell drives a nonzero tail word
    always_comb
    begin
        tail_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_word = tail_word | cell_tail[i];
        end
    end

    always_comb
    begin
        count_next     = count_reg;
        pop_value_next = pop_value_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            pop_value_next = '0;
            status_next    = ST_DONE;
            unique case (req_type)
                REQ_PUSH_FRONT, REQ_PUSH_BACK:
                begin
                    if (deq_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next = count_reg + COUNT_ONE;
                    end
                end
                REQ_POP_FRONT:
                begin
                    if (deq_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_value_next = front_ext;
                        count_next     = count_reg - COUNT_ONE;
                    end
                end
                REQ_POP_BACK:
                begin
                    if (deq_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        pop_value_next = tail_ext;
                        count_next     = count_reg - COUNT_ONE;
                    end
                end
                default:
                begin
                    status_next = ST_DONE;
                end
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_value_reg <= pop_value_next;
        status_reg    <= status_next;
    end

    assign out_valid  = out_valid_reg;
    assign pop_value  = pop_value_reg;
    assign status     = status_reg;
    assign fill_count = count_reg;
    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg == FULL_COUNT);

    a_empty_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) == !cell_occ[0])
        else $error("fill count disagrees with front cell occupancy");

    a_full_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == FULL_COUNT) == cell_occ[DEPTH-1])
        else $error("fill count disagrees with last cell occupancy");

    a_full_push_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && deq_full && (req_type == REQ_PUSH_FRONT || req_type == REQ_PUSH_BACK))
        |=> (status_reg == ST_FULL) && $stable(count_reg))
        else $error("push on full deque was not dropped");

    a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("fill count changed without a request");

    a_empty_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && deq_empty && (req_type == REQ_POP_FRONT || req_type == REQ_POP_BACK))
        |=> (status_reg == ST_EMPTY) && (pop_value_reg == '0))
        else $error("pop on empty deque returned a word");

endmodule

### tb/sv/double_ended_queue_unit_tb.sv
// self-checking testbench for the double-ended queue unit
module double_ended_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import deq_pkg::*;

    localparam int DEPTH      = 16;
    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int RANDOM_ITEMS = 500;

    typedef struct {
        logic [1:0]            kind;
        logic signed [IO_W-1:0] value;
    } deq_request_t;

    typedef struct packed {
        logic [IO_W-1:0]  pop_value;
        logic [1:0]       status;
        logic [CNT_W-1:0] fill_count;
        logic             is_empty;
        logic             is_full;
    } deq_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              req_type = '0;
    logic signed [IO_W-1:0]  push_value = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [IO_W-1:0]  pop_value;
    logic [1:0]              status;
    logic [CNT_W-1:0]        fill_count;
    logic                    is_empty;
    logic                    is_full;

    deq_request_t request_fifo[$];
    deq_result_t  expected_results[$];
    int           total_items;
    int           accepted_count = 0;
    int           results_seen = 0;
    int           error_count = 0;

    logic [WORD_WIDTH-1:0] ring_model [DEPTH];
    int                    head_ptr = 0;
    int                    tail_ptr = DEPTH - 1;
    int                    held = 0;

    int  hold_cycles = 0;
    bit  hold_done = 1'b0;
    wire steady_in  = (accepted_count >= 250) && (accepted_count < 400);
    wire steady_out = (results_seen >= 250) && (results_seen < 400);

    double_ended_queue_unit #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status),
        .fill_count (fill_count),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    function automatic deq_result_t deque_apply(logic [1:0] kind,
                                                logic signed [IO_W-1:0] value);
        deq_result_t r;
        r = '0;
        case (kind)
            REQ_PUSH_FRONT:
            begin
                if (held == DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    head_ptr = (head_ptr == 0) ? DEPTH - 1 : head_ptr - 1;
                    ring_model[head_ptr] = value[WORD_WIDTH-1:0];
                    held++;
                end
            end
            REQ_PUSH_BACK:
            begin
                if (held == DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    tail_ptr = (tail_ptr == DEPTH - 1) ? 0 : tail_ptr + 1;
                    ring_model[tail_ptr] = value[WORD_WIDTH-1:0];
                    held++;
                end
            end
            REQ_POP_FRONT:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.pop_value = IO_W'($signed(ring_model[head_ptr]));
                    head_ptr = (head_ptr == DEPTH - 1) ? 0 : head_ptr + 1;
                    held--;
                end
            end
            default:
            begin
                if (held == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    r.pop_value = IO_W'($signed(ring_model[tail_ptr]));
                    tail_ptr = (tail_ptr == 0) ? DEPTH - 1 : tail_ptr - 1;
                    held--;
                end
            end
        endcase
        r.fill_count = CNT_W'(held);
        r.is_empty   = (held == 0);
        r.is_full    = (held == DEPTH);
        return r;
    endfunction

    function automatic void check_field(string name, logic [IO_W-1:0] want_v,
                                        logic [IO_W-1:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
            error_count++;
        end
    endfunction

    function automatic logic signed [IO_W-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_request(logic [1:0] kind, logic signed [IO_W-1:0] value);
        deq_request_t item;
        item.kind  = kind;
        item.value = value;
        request_fifo.push_back(item);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        int mode;
        int burst;
        int push_pct;
        int n;
        logic [1:0] kind;
        rst_n = 1'b0;

        // empty pops, then both ends with extreme words, then fill to full, push twice while full and pop the back
        add_request(REQ_POP_FRONT, 32'sh12345678);
        add_request(REQ_POP_BACK, 32'sh7fffffff);
        add_request(REQ_PUSH_FRONT, 32'sh7fffffff);
        add_request(REQ_PUSH_BACK, 32'sh80000000);
        add_request(REQ_PUSH_FRONT, 32'sh00000000);
        add_request(REQ_PUSH_BACK, 32'shffffffff);
        add_request(REQ_POP_BACK, 32'sh0);
        add_request(REQ_POP_FRONT, 32'sh0);
        for (int i = 0; i < 14; i++)
        begin
            add_request(i[0] ? REQ_PUSH_BACK : REQ_PUSH_FRONT, 32'sh1 << (i * 2));
        end
        add_request(REQ_PUSH_FRONT, 32'sh55555555);
        add_request(REQ_PUSH_BACK, 32'shaaaaaaaa);
        add_request(REQ_POP_BACK, 32'sh0);

        // bursts leaning toward pushes, toward pops or balanced, so both full and empty recur
        n = 0;
        while (n < RANDOM_ITEMS)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(4, 24);
            push_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
            for (int i = 0; i < burst; i++)
            begin
                if ($urandom_range(99) < push_pct)
                    kind = $urandom_range(1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
                else
                    kind = $urandom_range(1) ? REQ_POP_BACK : REQ_POP_FRONT;
                add_request(kind, pick_word());
                n++;
            end
        end
        total_items = request_fifo.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        wait (accepted_count == total_items && expected_results.size() == 0);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : request_driver
        deq_request_t item;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            req_type   <= '0;
            push_value <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (request_fifo.size() > 0 && (steady_in || $urandom_range(99) >= 31))
            begin
                item = request_fifo.pop_front();
                in_valid   <= 1'b1;
                req_type   <= item.kind;
                push_value <= item.value;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready   <= (hold_cycles == 1);
        end
        else if (!hold_done && results_seen >= 100)
        begin
            // long receiver stall while requests keep coming
            hold_done   <= 1'b1;
            hold_cycles <= 150;
            out_ready   <= 1'b0;
        end
        else
        begin
            out_ready <= steady_out || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge clk)
    begin : result_monitor
        deq_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_results.push_back(deque_apply(req_type, push_value));
                accepted_count <= accepted_count + 1;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got %0h",
                             $time, pop_value);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("pop_value", want.pop_value, pop_value);
                    check_field("status", IO_W'(want.status), IO_W'(status));
                    check_field("fill_count", IO_W'(want.fill_count), IO_W'(fill_count));
                    check_field("is_empty", IO_W'(want.is_empty), IO_W'(is_empty));
                    check_field("is_full", IO_W'(want.is_full), IO_W'(is_full));
                end
            end
        end
    end

endmodule
